// ----- rtl/core/adaptive_fec_code_selector_defines.svh -----
// ----------------------------------------------------------------------------
// adaptive fec code selector assertion macros
// shared property wrappers for the selector's checks
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_FEC_CODE_SELECTOR_DEFINES_SVH
`define ADAPTIVE_FEC_CODE_SELECTOR_DEFINES_SVH

// same-cycle implication
`define AFCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("afcs check failed");

// next-cycle implication
`define AFCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("afcs check failed");

`endif

// ----- rtl/core/afcs_pkg.sv -----
// ----------------------------------------------------------------------------
// afcs_pkg
// types, constants and control encodings for the fec code selector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afcs_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [16:0] RATE_ONE = 17'd65536;

  // modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ADAPTIVE_EN   = 3'd0;
  localparam logic [2:0] REG_FEEDBACK_EN   = 3'd1;
  localparam logic [2:0] REG_CONTINUOUS_EN = 3'd2;
  localparam logic [2:0] REG_ENV_K         = 3'd3;
  localparam logic [2:0] REG_ENV_N         = 3'd4;
  localparam logic [2:0] REG_FB_MARGIN     = 3'd5;
  localparam logic [2:0] REG_MAX_RATE      = 3'd6;
  localparam logic [2:0] REG_CONT_MARGIN   = 3'd7;

  typedef struct packed {
    logic [15:0] k;
    logic [15:0] n;
    logic [15:0] t;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_RD,
    S_ADD_CMP,
    S_LAST_WAIT,
    S_FB_MUL,
    S_FB_APPLY,
    S_SEL_BRANCH,
    S_CONT_CHECK,
    S_DIV,
    S_CONT_RES,
    S_SEL_RD,
    S_SEL_MUL,
    S_SEL_CMP,
    S_LK_RD,
    S_LK_CMP,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_IDX_M1,
    ADDR_LAST
  } addr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_LOAD_CNT,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic {
    WR_SHIFT,
    WR_NEW
  } wr_sel_e;

  typedef enum logic [2:0] {
    RES_REJECT,
    RES_EMPTY,
    RES_ADD_OK,
    RES_ENTRY,
    RES_FALLBACK,
    RES_CONT_SEL,
    RES_CONT_LK
  } res_sel_e;

  typedef struct packed {
    logic      load_req;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic      wr_en;
    wr_sel_e   wr_sel;
    idx_op_e   idx_op;
    logic      last_ld;
    logic      cnt_inc;
    logic      fb_mul;
    logic      fb_apply;
    logic      clamp_rate;
    logic      sel_mul;
    logic      div_start;
    logic      div_step;
    logic      res_ld;
    res_sel_e  res_sel;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic [1:0]    mode;
    logic [CW-1:0] cnt;
    logic          cnt_zero;
    logic          add_ok;
    logic          add_greater;
    logic          idx_zero;
    logic          idx_last;
    logic          fb_en;
    logic          cont_en;
    logic          creq;
    logic          rate_zero;
    logic          lk_cont_ok;
    logic          sel_fit;
    logic          lk_match;
    logic          div_last;
  } sts_t;

endpackage

// ----- rtl/core/afcs_datapath.sv -----
// ----------------------------------------------------------------------------
// afcs_datapath
// code table, configuration, rate arithmetic, divider and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afcs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  input  logic [1:0]           mode_i,
  input  logic [15:0]          req_k_i,
  input  logic [15:0]          req_n_i,
  input  logic [15:0]          req_t_i,
  input  logic [15:0]          info_count_i,
  input  logic [16:0]          success_rate_i,
  input  logic                 continuous_req_i,
  input  afcs_pkg::cmd_t       cmd_i,
  output afcs_pkg::sts_t       sts_o,
  output logic [1:0]           status_o,
  output logic [15:0]          code_k_o,
  output logic [15:0]          code_n_o,
  output logic [15:0]          code_t_o,
  output logic [4:0]           entry_index_o,
  output logic                 is_continuous_o,
  output logic                 fallback_used_o
);

  // configuration
  logic        adaptive_en_q, feedback_en_q, continuous_en_q;
  logic [15:0] env_k_q, env_n_q, fb_margin_q, cont_margin_q;
  logic [16:0] max_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adaptive_en_q   <= 1'b0;
      feedback_en_q   <= 1'b0;
      continuous_en_q <= 1'b0;
      env_k_q         <= '0;
      env_n_q         <= '0;
      fb_margin_q     <= 16'd256;
      max_rate_q      <= afcs_pkg::RATE_ONE;
      cont_margin_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        afcs_pkg::REG_ADAPTIVE_EN:   adaptive_en_q   <= cfg_data_i[0];
        afcs_pkg::REG_FEEDBACK_EN:   feedback_en_q   <= cfg_data_i[0];
        afcs_pkg::REG_CONTINUOUS_EN: continuous_en_q <= cfg_data_i[0];
        afcs_pkg::REG_ENV_K:         env_k_q         <= cfg_data_i[15:0];
        afcs_pkg::REG_ENV_N:         env_n_q         <= cfg_data_i[15:0];
        afcs_pkg::REG_FB_MARGIN:     fb_margin_q     <= cfg_data_i[15:0];
        afcs_pkg::REG_MAX_RATE:      max_rate_q      <= cfg_data_i;
        afcs_pkg::REG_CONT_MARGIN:   cont_margin_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // entry count
  logic [afcs_pkg::CW-1:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // request capture
  logic [1:0]  mode_q;
  logic [15:0] k_q, n_q, t_q, info_q;
  logic [16:0] rate_q;
  logic        creq_q;

  // registered table read data
  afcs_pkg::entry_t rd_q;

  // rate working values
  logic [33:0] prod_q;
  logic [25:0] adj;
  logic [16:0] denom;
  assign adj   = prod_q[33:8];
  assign denom = {1'b0, info_q} + {1'b0, rd_q.n} - {1'b0, rd_q.k};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= mode_i;
      k_q    <= req_k_i;
      n_q    <= req_n_i;
      t_q    <= req_t_i;
      info_q <= info_count_i;
      creq_q <= continuous_req_i;
      rate_q <= (success_rate_i > afcs_pkg::RATE_ONE) ? afcs_pkg::RATE_ONE : success_rate_i;
    end else if (cmd_i.fb_apply) begin
      rate_q <= (adj >= 26'd65536) ? 17'd0 : afcs_pkg::RATE_ONE - adj[16:0];
    end else if (cmd_i.clamp_rate) begin
      if (rate_q > max_rate_q) rate_q <= max_rate_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fb_mul) begin
      prod_q <= 34'(afcs_pkg::RATE_ONE - rate_q) * 34'(fb_margin_q);
    end else if (cmd_i.sel_mul) begin
      prod_q <= rate_q * denom;
    end
  end

  // table pointer
  logic [afcs_pkg::CW-1:0] idx_q;
  always_ff @(posedge clk_i) begin
    case (cmd_i.idx_op)
      afcs_pkg::IDX_CLR:      idx_q <= '0;
      afcs_pkg::IDX_LOAD_CNT: idx_q <= cnt_q;
      afcs_pkg::IDX_INC:      idx_q <= idx_q + 1'b1;
      afcs_pkg::IDX_DEC:      idx_q <= idx_q - 1'b1;
      default: ;
    endcase
  end

  // code table memory
  afcs_pkg::entry_t        mem_q [afcs_pkg::TABLE_DEPTH];
  afcs_pkg::entry_t        wr_data;
  logic [afcs_pkg::CW-1:0] addr_full;
  logic [afcs_pkg::CW-1:0] idx_m1, cnt_m1;

  assign idx_m1 = idx_q - 1'b1;
  assign cnt_m1 = cnt_q - 1'b1;

  always_comb begin
    case (cmd_i.addr_sel)
      afcs_pkg::ADDR_IDX_M1: addr_full = idx_m1;
      afcs_pkg::ADDR_LAST:   addr_full = cnt_m1;
      default:               addr_full = idx_q;
    endcase
  end

  assign wr_data = (cmd_i.wr_sel == afcs_pkg::WR_NEW) ?
                   afcs_pkg::entry_t'{k: k_q, n: n_q, t: t_q} : rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[idx_q[afcs_pkg::AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[addr_full[afcs_pkg::AW-1:0]];
    end
  end

  // last entry copy
  afcs_pkg::entry_t last_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.last_ld) begin
      last_q <= rd_q;
    end
  end

  // restoring divider, quotient shifts into the dividend register
  logic [31:0] dvd_q;
  logic [16:0] rem_q;
  logic [4:0]  div_cnt_q;
  logic [17:0] rem_sh;
  logic        q_bit;

  assign rem_sh = {rem_q, dvd_q[31]};
  assign q_bit  = (rem_sh >= {1'b0, rate_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q     <= {info_q, 16'd0} + {15'd0, rate_q} - 32'd1;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= q_bit ? 17'(rem_sh - {1'b0, rate_q}) : rem_sh[16:0];
      dvd_q     <= {dvd_q[30:0], q_bit};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // continuous n
  logic [32:0] cont_sum;
  logic [15:0] cont_n;
  assign cont_sum = {1'b0, dvd_q} + {17'd0, cont_margin_q};
  always_comb begin
    if (rate_q == 17'd0 || cont_sum > {17'd0, last_q.n}) begin
      cont_n = last_q.n;
    end else begin
      cont_n = cont_sum[15:0];
    end
  end

  // status
  logic add_rule;
  assign add_rule = (cnt_q < afcs_pkg::CW'(afcs_pkg::TABLE_DEPTH)) && (k_q < n_q) &&
                    ((adaptive_en_q && k_q <= env_k_q) ||
                     (!adaptive_en_q && !continuous_en_q && k_q == env_k_q &&
                      (n_q == env_n_q || feedback_en_q)));

  always_comb begin
    sts_o             = '0;
    sts_o.mode        = mode_q;
    sts_o.cnt         = cnt_q;
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.add_ok      = add_rule;
    sts_o.add_greater = (rd_q.k > k_q) || (rd_q.k == k_q && rd_q.n > n_q);
    sts_o.idx_zero    = (idx_q == '0);
    sts_o.idx_last    = (idx_q == cnt_m1);
    sts_o.fb_en       = feedback_en_q;
    sts_o.cont_en     = continuous_en_q;
    sts_o.creq        = creq_q;
    sts_o.rate_zero   = (rate_q == 17'd0);
    // rd_q holds the last entry while this is used
    sts_o.lk_cont_ok  = continuous_en_q && (n_q > k_q) && (n_q <= rd_q.n);
    sts_o.sel_fit     = ({2'b00, info_q, 16'd0} <= prod_q) && (info_q <= rd_q.k);
    sts_o.lk_match    = (rd_q.k == k_q) && (rd_q.n == n_q);
    sts_o.div_last    = (div_cnt_q == 5'(afcs_pkg::DIV_STEPS - 1));
  end

  // result staging
  logic [1:0]  res_status;
  logic [15:0] res_k, res_n, res_t;
  logic [4:0]  res_idx;
  logic        res_cont, res_fb;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      res_status <= afcs_pkg::ST_OK;
      res_k      <= '0;
      res_n      <= '0;
      res_t      <= '0;
      res_idx    <= '0;
      res_cont   <= 1'b0;
      res_fb     <= 1'b0;
      case (cmd_i.res_sel)
        afcs_pkg::RES_REJECT: res_status <= afcs_pkg::ST_REJECT;
        afcs_pkg::RES_EMPTY:  res_status <= afcs_pkg::ST_EMPTY;
        afcs_pkg::RES_ADD_OK: begin
          res_k   <= k_q;
          res_n   <= n_q;
          res_t   <= t_q;
          res_idx <= 5'(idx_q);
        end
        afcs_pkg::RES_ENTRY: begin
          res_k   <= rd_q.k;
          res_n   <= rd_q.n;
          res_t   <= rd_q.t;
          res_idx <= 5'(idx_q);
        end
        afcs_pkg::RES_FALLBACK: begin
          res_k   <= last_q.k;
          res_n   <= last_q.n;
          res_t   <= last_q.t;
          res_idx <= 5'(cnt_m1);
          res_fb  <= 1'b1;
        end
        afcs_pkg::RES_CONT_SEL: begin
          res_k    <= info_q;
          res_n    <= cont_n;
          res_t    <= last_q.t;
          res_cont <= 1'b1;
        end
        afcs_pkg::RES_CONT_LK: begin
          res_k    <= k_q;
          res_n    <= n_q;
          res_t    <= rd_q.t;
          res_cont <= 1'b1;
        end
        default: res_status <= afcs_pkg::ST_REJECT;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      status_o        <= res_status;
      code_k_o        <= res_k;
      code_n_o        <= res_n;
      code_t_o        <= res_t;
      entry_index_o   <= res_idx;
      is_continuous_o <= res_cont;
      fallback_used_o <= res_fb;
    end
  end

endmodule

// ----- rtl/core/afcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// afcs_ctrl
// sequencer for add, select and lookup transactions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afcs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  afcs_pkg::sts_t sts_i,
  output afcs_pkg::cmd_t cmd_o
);

  afcs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_free;

  assign in_ready_o  = (state_q == afcs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afcs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afcs_pkg::S_IDLE:       if (in_valid_i) state_d = afcs_pkg::S_DISPATCH;
      afcs_pkg::S_DISPATCH: begin
        if (sts_i.mode == afcs_pkg::MODE_ADD) begin
          state_d = sts_i.add_ok ? afcs_pkg::S_ADD_RD : afcs_pkg::S_DONE;
        end else if (sts_i.mode == afcs_pkg::MODE_SELECT ||
                     sts_i.mode == afcs_pkg::MODE_LOOKUP) begin
          state_d = sts_i.cnt_zero ? afcs_pkg::S_DONE : afcs_pkg::S_LAST_WAIT;
        end else begin
          state_d = afcs_pkg::S_DONE;
        end
      end
      afcs_pkg::S_ADD_RD:
        state_d = sts_i.idx_zero ? afcs_pkg::S_DONE : afcs_pkg::S_ADD_CMP;
      afcs_pkg::S_ADD_CMP:
        state_d = sts_i.add_greater ? afcs_pkg::S_ADD_RD : afcs_pkg::S_DONE;
      afcs_pkg::S_LAST_WAIT: begin
        if (sts_i.mode == afcs_pkg::MODE_SELECT) begin
          state_d = sts_i.fb_en ? afcs_pkg::S_FB_MUL : afcs_pkg::S_SEL_BRANCH;
        end else begin
          state_d = sts_i.creq ? afcs_pkg::S_DONE : afcs_pkg::S_LK_RD;
        end
      end
      afcs_pkg::S_FB_MUL:     state_d = afcs_pkg::S_FB_APPLY;
      afcs_pkg::S_FB_APPLY:   state_d = afcs_pkg::S_SEL_BRANCH;
      afcs_pkg::S_SEL_BRANCH:
        state_d = sts_i.cont_en ? afcs_pkg::S_CONT_CHECK : afcs_pkg::S_SEL_RD;
      afcs_pkg::S_CONT_CHECK:
        state_d = sts_i.rate_zero ? afcs_pkg::S_DONE : afcs_pkg::S_DIV;
      afcs_pkg::S_DIV:        if (sts_i.div_last) state_d = afcs_pkg::S_CONT_RES;
      afcs_pkg::S_CONT_RES:   state_d = afcs_pkg::S_DONE;
      afcs_pkg::S_SEL_RD:     state_d = afcs_pkg::S_SEL_MUL;
      afcs_pkg::S_SEL_MUL:    state_d = afcs_pkg::S_SEL_CMP;
      afcs_pkg::S_SEL_CMP:
        if (sts_i.sel_fit || sts_i.idx_last) state_d = afcs_pkg::S_DONE;
        else                                 state_d = afcs_pkg::S_SEL_RD;
      afcs_pkg::S_LK_RD:      state_d = afcs_pkg::S_LK_CMP;
      afcs_pkg::S_LK_CMP:
        if (sts_i.lk_match || sts_i.idx_last) state_d = afcs_pkg::S_DONE;
        else                                  state_d = afcs_pkg::S_LK_RD;
      afcs_pkg::S_DONE:       if (out_free) state_d = afcs_pkg::S_IDLE;
      default:                state_d = afcs_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = afcs_pkg::ADDR_IDX;
    cmd_o.wr_sel   = afcs_pkg::WR_NEW;
    cmd_o.idx_op   = afcs_pkg::IDX_HOLD;
    cmd_o.res_sel  = afcs_pkg::RES_REJECT;
    case (state_q)
      afcs_pkg::S_IDLE: cmd_o.load_req = in_valid_i;
      afcs_pkg::S_DISPATCH: begin
        if (sts_i.mode == afcs_pkg::MODE_ADD) begin
          cmd_o.idx_op = afcs_pkg::IDX_LOAD_CNT;
          cmd_o.res_ld = !sts_i.add_ok;
        end else if (sts_i.mode == afcs_pkg::MODE_SELECT ||
                     sts_i.mode == afcs_pkg::MODE_LOOKUP) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = afcs_pkg::ADDR_LAST;
          cmd_o.res_ld   = sts_i.cnt_zero;
          cmd_o.res_sel  = afcs_pkg::RES_EMPTY;
        end else begin
          cmd_o.res_ld = 1'b1;
        end
      end
      afcs_pkg::S_ADD_RD: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = afcs_pkg::RES_ADD_OK;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = afcs_pkg::ADDR_IDX_M1;
        end
      end
      afcs_pkg::S_ADD_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.add_greater) begin
          // move the larger entry up one slot
          cmd_o.wr_sel = afcs_pkg::WR_SHIFT;
          cmd_o.idx_op = afcs_pkg::IDX_DEC;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = afcs_pkg::RES_ADD_OK;
        end
      end
      afcs_pkg::S_LAST_WAIT: begin
        cmd_o.last_ld = 1'b1;
        cmd_o.idx_op  = afcs_pkg::IDX_CLR;
        if (sts_i.mode == afcs_pkg::MODE_LOOKUP && sts_i.creq) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = sts_i.lk_cont_ok ? afcs_pkg::RES_CONT_LK : afcs_pkg::RES_REJECT;
        end
      end
      afcs_pkg::S_FB_MUL:     cmd_o.fb_mul     = 1'b1;
      afcs_pkg::S_FB_APPLY:   cmd_o.fb_apply   = 1'b1;
      afcs_pkg::S_SEL_BRANCH: cmd_o.clamp_rate = sts_i.cont_en;
      afcs_pkg::S_CONT_CHECK: begin
        cmd_o.div_start = !sts_i.rate_zero;
        cmd_o.res_ld    = sts_i.rate_zero;
        cmd_o.res_sel   = afcs_pkg::RES_CONT_SEL;
      end
      afcs_pkg::S_DIV:        cmd_o.div_step = 1'b1;
      afcs_pkg::S_CONT_RES: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.res_sel = afcs_pkg::RES_CONT_SEL;
      end
      afcs_pkg::S_SEL_RD:     cmd_o.rd_en   = 1'b1;
      afcs_pkg::S_SEL_MUL:    cmd_o.sel_mul = 1'b1;
      afcs_pkg::S_SEL_CMP: begin
        if (sts_i.sel_fit) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = afcs_pkg::RES_ENTRY;
        end else if (sts_i.idx_last) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = afcs_pkg::RES_FALLBACK;
        end else begin
          cmd_o.idx_op = afcs_pkg::IDX_INC;
        end
      end
      afcs_pkg::S_LK_RD:      cmd_o.rd_en = 1'b1;
      afcs_pkg::S_LK_CMP: begin
        if (sts_i.lk_match) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_sel = afcs_pkg::RES_ENTRY;
        end else if (sts_i.idx_last) begin
          cmd_o.res_ld = 1'b1;
        end else begin
          cmd_o.idx_op = afcs_pkg::IDX_INC;
        end
      end
      afcs_pkg::S_DONE:       cmd_o.out_ld = out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/adaptive_fec_code_selector.sv -----
// ----------------------------------------------------------------------------
// adaptive_fec_code_selector
// sorted (k,n,t) code table with add, select and lookup transactions
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        input      in_valid_i/in_ready_o   mode, req_k/n/t, info_count, success_rate,
//                                              continuous_req
// out       output     out_valid_o/out_ready_i status, code_k/n/t, entry_index,
//                                              is_continuous, fallback_used
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction at a time; the table is a single-port memory with registered read
// add: shifts each larger entry up one slot until the insertion point is found
// table select: scans the table from the head, after a feedback rate step when enabled;
// lookup: scans the table from the head for a matching entry
// continuous select: computes n with the 32-step restoring divider
// reset clears the entry count and control; a stalled result frees the sequencer
// for the next transaction, which then waits in its final state for the output slot
`timescale 1ns / 1ps
`include "adaptive_fec_code_selector_defines.svh"

module adaptive_fec_code_selector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] req_k_i,
  input  logic [15:0] req_n_i,
  input  logic [15:0] req_t_i,
  input  logic [15:0] info_count_i,
  input  logic [16:0] success_rate_i,
  input  logic        continuous_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] code_k_o,
  output logic [15:0] code_n_o,
  output logic [15:0] code_t_o,
  output logic [4:0]  entry_index_o,
  output logic        is_continuous_o,
  output logic        fallback_used_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  afcs_pkg::cmd_t cmd;
  afcs_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  afcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  afcs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mode_i           (mode_i),
    .req_k_i          (req_k_i),
    .req_n_i          (req_n_i),
    .req_t_i          (req_t_i),
    .info_count_i     (info_count_i),
    .success_rate_i   (success_rate_i),
    .continuous_req_i (continuous_req_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .code_k_o         (code_k_o),
    .code_n_o         (code_n_o),
    .code_t_o         (code_t_o),
    .entry_index_o    (entry_index_o),
    .is_continuous_o  (is_continuous_o),
    .fallback_used_o  (fallback_used_o)
  );

  `AFCS_ASSERT_IMP(a_cnt_bound, 1'b1, sts.cnt <= afcs_pkg::CW'(afcs_pkg::TABLE_DEPTH))
  `AFCS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `AFCS_ASSERT_IMP(a_fb_not_cont, out_valid_o && fallback_used_o, !is_continuous_o && status_o == afcs_pkg::ST_OK)

endmodule

// ----- dv/adaptive_fec_code_selector_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_fec_code_selector_test
// drives add, select and lookup transactions through the code selector under a
// series of register settings, predicts results with a local copy of the sorted
// code table or takes them from directed rows; compares each output field in order
// ----------------------------------------------------------------------------

module adaptive_fec_code_selector_test;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_SETTING = 190;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] k;
    logic [15:0] n;
    logic [15:0] t;
    logic [15:0] info;
    logic [16:0] rate;
    logic        creq;
  } code_req_t;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] k;
    logic [15:0] n;
    logic [15:0] t;
    logic [4:0]  idx;
    logic        cont;
    logic        fb;
  } code_res_t;

  typedef struct {
    code_req_t req;
    bit        typed;
    code_res_t res;
  } dir_row_t;

  typedef struct {
    logic        ad;
    logic        fb;
    logic        cont;
    logic [15:0] ek;
    logic [15:0] en;
    logic [15:0] fm;
    logic [16:0] mr;
    logic [15:0] cm;
    bit          calm;
  } setting_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  mode_i;
  logic [15:0] req_k_i, req_n_i, req_t_i, info_count_i;
  logic [16:0] success_rate_i;
  logic        continuous_req_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] code_k_o, code_n_o, code_t_o;
  logic [4:0]  entry_index_o;
  logic        is_continuous_o, fallback_used_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [16:0] cfg_data_i;

  adaptive_fec_code_selector dut (.*);

  // local copy of the selector state and registers
  logic [15:0] tbl_k[afcs_pkg::TABLE_DEPTH];
  logic [15:0] tbl_n[afcs_pkg::TABLE_DEPTH];
  logic [15:0] tbl_t[afcs_pkg::TABLE_DEPTH];
  int unsigned fill;
  logic        r_ad, r_fb, r_cont;
  logic [15:0] r_ek, r_en, r_fm, r_cm;
  logic [16:0] r_mr;

  code_res_t pending_codes[$];
  int unsigned mismatches, results_seen, items_sent, fallbacks, conts;
  bit calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic code_res_t mk_res(logic [1:0] st, logic [15:0] k, logic [15:0] n,
                                       logic [15:0] t, logic [4:0] idx,
                                       logic cont, logic fb);
    code_res_t r;
    r.st = st; r.k = k; r.n = n; r.t = t; r.idx = idx; r.cont = cont; r.fb = fb;
    return r;
  endfunction

  function automatic code_res_t select_code(longint unsigned info, longint unsigned rate);
    int unsigned last;
    longint unsigned adj, n, lastn, den;
    if (fill == 0) return mk_res(afcs_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0);
    last = fill - 1;
    if (rate > 65536) rate = 65536;
    if (r_fb) begin
      adj = ((65536 - rate) * r_fm) >> 8;
      rate = (adj >= 65536) ? 0 : 65536 - adj;
    end
    if (r_cont) begin
      lastn = tbl_n[last];
      if (rate > r_mr) rate = r_mr;
      if (rate == 0) n = lastn;
      else begin
        n = (info * 65536 + rate - 1) / rate + r_cm;
        if (n > lastn) n = lastn;
      end
      return mk_res(afcs_pkg::ST_OK, info[15:0], n[15:0], tbl_t[last], 0, 1, 0);
    end
    for (int i = 0; i < fill; i++) begin
      den = info + tbl_n[i] - tbl_k[i];
      if (info * 65536 <= rate * den && info <= tbl_k[i])
        return mk_res(afcs_pkg::ST_OK, tbl_k[i], tbl_n[i], tbl_t[i], i[4:0], 0, 0);
    end
    return mk_res(afcs_pkg::ST_OK, tbl_k[last], tbl_n[last], tbl_t[last], last[4:0], 0, 1);
  endfunction

  function automatic code_res_t predict_code(code_req_t q);
    int unsigned pos;
    bit ok;
    case (q.mode)
      afcs_pkg::MODE_ADD: begin
        ok = fill < afcs_pkg::TABLE_DEPTH && q.k < q.n &&
             ((r_ad && q.k <= r_ek) ||
              (!r_ad && !r_cont && q.k == r_ek && (q.n == r_en || r_fb)));
        if (!ok) return mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0);
        pos = fill;
        while (pos > 0 && (tbl_k[pos-1] > q.k ||
                           (tbl_k[pos-1] == q.k && tbl_n[pos-1] > q.n)))
          pos--;
        for (int i = fill; i > pos; i--) begin
          tbl_k[i] = tbl_k[i-1]; tbl_n[i] = tbl_n[i-1]; tbl_t[i] = tbl_t[i-1];
        end
        tbl_k[pos] = q.k; tbl_n[pos] = q.n; tbl_t[pos] = q.t;
        fill++;
        return mk_res(afcs_pkg::ST_OK, q.k, q.n, q.t, pos[4:0], 0, 0);
      end
      afcs_pkg::MODE_SELECT: return select_code(q.info, q.rate);
      afcs_pkg::MODE_LOOKUP: begin
        if (fill == 0) return mk_res(afcs_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0);
        if (q.creq) begin
          if (r_cont && q.n > q.k && q.n <= tbl_n[fill-1])
            return mk_res(afcs_pkg::ST_OK, q.k, q.n, tbl_t[fill-1], 0, 1, 0);
          return mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0);
        end
        for (int i = 0; i < fill; i++)
          if (tbl_k[i] == q.k && tbl_n[i] == q.n)
            return mk_res(afcs_pkg::ST_OK, q.k, q.n, tbl_t[i], i[4:0], 0, 0);
        return mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0);
      end
      default: return mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0);
    endcase
  endfunction

  // caller sits at a rising edge; valid stays high on return unless a gap was taken
  task automatic send_code_req(code_req_t q, bit typed, code_res_t res);
    code_res_t p;
    in_valid_i <= 1'b1;
    mode_i <= q.mode; req_k_i <= q.k; req_n_i <= q.n; req_t_i <= q.t;
    info_count_i <= q.info; success_rate_i <= q.rate; continuous_req_i <= q.creq;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_code(q);
    pending_codes.push_back(typed ? res : p);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_codes();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      afcs_pkg::REG_ADAPTIVE_EN:   r_ad = data[0];
      afcs_pkg::REG_FEEDBACK_EN:   r_fb = data[0];
      afcs_pkg::REG_CONTINUOUS_EN: r_cont = data[0];
      afcs_pkg::REG_ENV_K:         r_ek = data[15:0];
      afcs_pkg::REG_ENV_N:         r_en = data[15:0];
      afcs_pkg::REG_FB_MARGIN:     r_fm = data[15:0];
      afcs_pkg::REG_MAX_RATE:      r_mr = data;
      default:                     r_cm = data[15:0];
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic code_req_t rand_code_req();
    code_req_t q;
    int unsigned pick, e;
    pick = $urandom_range(0, 99);
    q.mode = pick < 18 ? afcs_pkg::MODE_ADD : pick < 60 ? afcs_pkg::MODE_SELECT :
             pick < 95 ? afcs_pkg::MODE_LOOKUP : MODE_UNUSED;
    pick = $urandom_range(0, 9);
    q.k = pick < 3 ? r_ek : pick < 6 ? 16'($urandom_range(0, 200)) : 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 4) q.n = 16'(q.k + $urandom_range(1, 300));
    else if (pick < 6) q.n = r_en;
    else q.n = 16'($urandom);
    q.t = 16'($urandom);
    q.creq = $urandom_range(0, 1);
    if (q.mode == afcs_pkg::MODE_LOOKUP && fill != 0 && $urandom_range(0, 1)) begin
      e = $urandom_range(0, fill - 1);
      q.k = tbl_k[e]; q.n = tbl_n[e];
      q.creq = $urandom_range(0, 3) == 0;
    end
    q.info = $urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    pick = $urandom_range(0, 19);
    q.rate = pick == 0 ? 17'd0 : pick < 3 ? 17'($urandom_range(65536, 131071))
                                          : 17'($urandom_range(0, 65536));
    return q;
  endfunction

  function automatic dir_row_t row(logic [1:0] mode, logic [15:0] k, logic [15:0] n,
                                   logic [15:0] t, logic [15:0] info, logic [16:0] rate,
                                   logic creq, bit typed, code_res_t res);
    dir_row_t d;
    d.req.mode = mode; d.req.k = k; d.req.n = n; d.req.t = t;
    d.req.info = info; d.req.rate = rate; d.req.creq = creq;
    d.typed = typed; d.res = res;
    return d;
  endfunction

  // result checker and stall watchdog
  int unsigned stall_cycles;
  always @(posedge clk_i) begin
    code_res_t e;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", status_o);
      end else begin
        e = pending_codes.pop_front();
        if (fallback_used_o) fallbacks++;
        if (is_continuous_o) conts++;
        if (status_o !== e.st || code_k_o !== e.k || code_n_o !== e.n ||
            code_t_o !== e.t || entry_index_o !== e.idx ||
            is_continuous_o !== e.cont || fallback_used_o !== e.fb) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st%0d k%0d n%0d t%0d i%0d c%0d f%0d, ",
                      "got st%0d k%0d n%0d t%0d i%0d c%0d f%0d"},
                     e.st, e.k, e.n, e.t, e.idx, e.cont, e.fb, status_o, code_k_o,
                     code_n_o, code_t_o, entry_index_o, is_continuous_o,
                     fallback_used_o);
        end
      end
    end
  end

  always @(posedge clk_i)
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);

  dir_row_t  dir_rows[$];
  setting_t  settings[$];
  code_res_t none;

  initial begin
    setting_t s;
    rst_ni = 1'b0; in_valid_i = 1'b0; out_ready_i = 1'b0; cfg_valid_i = 1'b0;
    mode_i = afcs_pkg::MODE_ADD; req_k_i = 0; req_n_i = 0; req_t_i = 0; info_count_i = 0;
    success_rate_i = 0; continuous_req_i = 0; cfg_index_i = afcs_pkg::REG_ADAPTIVE_EN;
    cfg_data_i = 0; calm = 0; stall_cycles = 0;
    fill = 0; r_ad = 0; r_fb = 0; r_cont = 0; r_ek = 0; r_en = 0;
    r_fm = 16'd256; r_mr = afcs_pkg::RATE_ONE; r_cm = 0;
    mismatches = 0; results_seen = 0; items_sent = 0; fallbacks = 0; conts = 0;
    none = mk_res(afcs_pkg::ST_OK, 0, 0, 0, 0, 0, 0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: empty table, extremes, sorting and special cases
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 5, 65536, 0, 1,
                           mk_res(afcs_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_LOOKUP, 3, 9, 0, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row(MODE_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff, 1, 1,
                           mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_ADD, 0, 65535, 65535, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_OK, 0, 65535, 65535, 0, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_ADD, 65535, 65535, 7, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_ADD, 100, 200, 1, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_OK, 100, 200, 1, 1, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_ADD, 100, 150, 2, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_OK, 100, 150, 2, 1, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_ADD, 50, 60, 3, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_OK, 50, 60, 3, 1, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_ADD, 65534, 65535, 0, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_OK, 65534, 65535, 0, 4, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_LOOKUP, 100, 200, 0, 0, 0, 0, 0, none));
    dir_rows.push_back(row(afcs_pkg::MODE_LOOKUP, 7, 8, 0, 0, 0, 0, 1,
                           mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_LOOKUP, 5, 10, 0, 0, 0, 1, 1,
                           mk_res(afcs_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 0, 0, 0, 0, none));
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 65535, 65536, 0, 0, none));
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 10, 17'h1ffff, 0, 0, none));
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 50, 32768, 0, 0, none));
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 65535, 1, 0, 0, none));
    dir_rows.push_back(row(afcs_pkg::MODE_SELECT, 0, 0, 0, 100, 65536, 0, 0, none));

    write_reg(afcs_pkg::REG_ADAPTIVE_EN, 1);
    write_reg(afcs_pkg::REG_ENV_K, 17'd65535);
    foreach (dir_rows[i]) send_code_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    drain_codes();

    // ad fb cont env_k env_n fb_margin max_rate cont_margin calm
    settings.push_back('{0, 0, 0, 1000, 1500, 256, 65536, 0, 0});
    settings.push_back('{0, 1, 0, 2000, 0, 512, 65536, 0, 0});
    settings.push_back('{1, 0, 0, 65535, 0, 256, 65536, 0, 0});
    settings.push_back('{1, 1, 1, 65535, 0, 0, 1, 65535, 0});
    settings.push_back('{0, 1, 1, 0, 65535, 65535, 65536, 0, 0});
    settings.push_back('{1, 0, 1, 30000, 100, 256, 40000, 3, 0});
    settings.push_back('{1, 1, 0, 0, 0, 300, 65536, 0, 1});
    settings.push_back('{0, 0, 0, 65535, 65535, 128, 65536, 0, 0});
    foreach (settings[p]) begin
      s = settings[p];
      write_reg(afcs_pkg::REG_ADAPTIVE_EN, s.ad);
      write_reg(afcs_pkg::REG_FEEDBACK_EN, s.fb);
      write_reg(afcs_pkg::REG_CONTINUOUS_EN, s.cont);
      write_reg(afcs_pkg::REG_ENV_K, s.ek);
      write_reg(afcs_pkg::REG_ENV_N, s.en);
      write_reg(afcs_pkg::REG_FB_MARGIN, s.fm);
      write_reg(afcs_pkg::REG_MAX_RATE, s.mr);
      write_reg(afcs_pkg::REG_CONT_MARGIN, s.cm);
      calm = s.calm;
      repeat (ITEMS_PER_SETTING) send_code_req(rand_code_req(), 0, none);
      drain_codes();
      calm = 0;
    end

    $display("%0d transactions over %0d register settings, table filled to %0d entries",
             items_sent, settings.size() + 1, fill);
    $display("%0d results checked, %0d fallbacks, %0d continuous codes, %0d mismatches",
             results_seen, fallbacks, conts, mismatches);
    if (mismatches == 0 && pending_codes.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
